FILE: sv/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int NUM_WORKERS = 16;
  localparam int COUNT_WIDTH = 8;
  localparam int IDX_W       = 4;   // worker index
  localparam int NW_W        = 5;   // worker count, holds NUM_WORKERS itself
  localparam int ARG_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [NW_W-1:0]        NW_MAX    = NW_W'(NUM_WORKERS);
  localparam logic signed [ARG_W-1:0] ARG_NONE = -9'sd1;

  // Operation codes of an input item
  localparam logic [1:0] OP_TERM  = 2'd0;
  localparam logic [1:0] OP_STAT  = 2'd1;
  localparam logic [1:0] OP_ASK   = 2'd2;

  // Commands of a result item
  localparam logic [1:0] CMD_TERM = 2'd0;
  localparam logic [1:0] CMD_SEND = 2'd1;
  localparam logic [1:0] CMD_RECV = 2'd2;
  localparam logic [1:0] CMD_FIN  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MANAGER_ID   = 2'd1;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] q;
    logic [COUNT_WIDTH-1:0] s;
  } cnt_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] id;
  } mst_t;

  typedef struct packed {
    logic             cnt_we;
    logic             mst_we;
    logic [IDX_W-1:0] addr;
    cnt_t             cnt;
    mst_t             mst;
  } tbl_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BCAST,
    ST_SCAN,
    ST_MREAD,
    ST_MCHECK,
    ST_TERM,
    ST_SEND,
    ST_RECV,
    ST_FIN,
    ST_WRT,
    ST_WRS
  } state_t;

endpackage

FILE: sv/wsd_in_if.sv
`timescale 1ns / 1ps

interface wsd_in_if import wsd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic [IDX_W-1:0]       source;
  logic [COUNT_WIDTH-1:0] value_a;
  logic [COUNT_WIDTH-1:0] value_b;

  modport source_mp (output valid, op, source, value_a, value_b, input ready);
  modport sink (input valid, op, source, value_a, value_b, output ready);
endinterface

FILE: sv/wsd_out_if.sv
`timescale 1ns / 1ps

interface wsd_out_if import wsd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        dest;
  logic [1:0]              cmd;
  logic signed [ARG_W-1:0] arg_a;
  logic signed [ARG_W-1:0] arg_b;
  logic                    last;

  modport source_mp (output valid, dest, cmd, arg_a, arg_b, last, input ready);
  modport sink (input valid, dest, cmd, arg_a, arg_b, last, output ready);
endinterface

FILE: sv/wsd_cfg_if.sv
`timescale 1ns / 1ps

interface wsd_cfg_if import wsd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source_mp (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/work_steal_dispatcher.sv
`timescale 1ns / 1ps
// A status update writes the table; a terminate notice is broadcast over the active workers.
// An ask for work scans the active workers and may add a finished-space notice; the asker
// gets a terminate notice when no target is found or once done.
// Throughput: one item at a time; the worker scan reads one table entry per cycle
// through the table memory's single read port.
// Reset: synchronous, active low; the table reads as cleared at once (entry valid bits).

module work_steal_dispatcher import wsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  wsd_in_if.sink        in_chan,
  wsd_out_if.source_mp  out_chan,
  wsd_cfg_if.sink       cfg_chan
);

  // Configuration
  logic [NW_W-1:0]  worker_count_r;
  logic [IDX_W-1:0] manager_id_r;
  logic [NW_W-1:0]  n;
  logic [COUNT_WIDTH-1:0] n_plus1;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_count_r <= NW_MAX;
      manager_id_r   <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_WORKER_COUNT: worker_count_r <= cfg_chan.data;
        CFG_MANAGER_ID:   manager_id_r   <= cfg_chan.data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Active workers: count capped at the table depth
  assign n       = (worker_count_r > NW_MAX) ? NW_MAX : worker_count_r;
  assign n_plus1 = COUNT_WIDTH'(n) + COUNT_WIDTH'(1);

  // Control and item registers
  state_t state_r, state_nxt;
  logic             done_r;
  logic [IDX_W-1:0] src_r;
  logic [COUNT_WIDTH-1:0] va_r;
  logic [NW_W-1:0]  i_r;       // scan / broadcast counter
  logic             pv_r;      // table read data in flight belongs to the scan
  logic [IDX_W-1:0] pidx_r;
  logic [COUNT_WIDTH-1:0] minq_r, mins_r;
  logic [IDX_W-1:0] tgt_r;
  logic             found_r;
  logic             smv_r;     // asker has a master
  logic [IDX_W-1:0] sm_r;
  logic             fin_r;
  logic             wb_r;      // asker entry to be written after terminate

  logic in_fire;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Table memory
  logic [IDX_W-1:0] rd_addr;
  cnt_t             rd_cnt;
  mst_t             rd_mst;
  tbl_wr_t          wr;

  wsd_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_cnt  (rd_cnt),
    .rd_mst  (rd_mst),
    .wr      (wr)
  );

  // Output register
  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_dest_r;
  logic [1:0]              out_cmd_r;
  logic signed [ARG_W-1:0] out_arg_a_r, out_arg_b_r;
  logic                    out_last_r;
  logic                    slot_free;
  logic                    emit_en;
  logic [IDX_W-1:0]        e_dest;
  logic [1:0]              e_cmd;
  logic signed [ARG_W-1:0] e_arg_a, e_arg_b;
  logic                    e_last;
  logic                    out_fire;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign out_fire  = emit_en && slot_free;

  assign out_chan.valid = out_valid_r;
  assign out_chan.dest  = out_dest_r;
  assign out_chan.cmd   = out_cmd_r;
  assign out_chan.arg_a = out_arg_a_r;
  assign out_chan.arg_b = out_arg_b_r;
  assign out_chan.last  = out_last_r;

  // Broadcast: skip the manager and the named worker; last when none remains above
  logic                   bc_excl;
  logic [NW_W-1:0]        bc_rem;
  logic [1:0]             bc_skip;
  logic                   bc_last;
  logic [COUNT_WIDTH-1:0] mgr_w, i_w, n_w;
  logic                   mgr_above, va_above;

  assign mgr_w     = COUNT_WIDTH'(manager_id_r);
  assign i_w       = COUNT_WIDTH'(i_r);
  assign n_w       = COUNT_WIDTH'(n);
  assign bc_excl   = (i_w == mgr_w) || (i_w == va_r);
  assign mgr_above = (mgr_w > i_w) && (mgr_w < n_w);
  assign va_above  = (va_r > i_w) && (va_r < n_w) && (va_r != mgr_w);
  assign bc_skip   = 2'(mgr_above) + 2'(va_above);
  assign bc_rem    = n - i_r - NW_W'(1);
  assign bc_last   = (bc_rem == NW_W'(bc_skip));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_chan.op)
            OP_TERM: state_nxt = ST_BCAST;
            OP_ASK: begin
              if ({1'b0, in_chan.source} < n) begin
                state_nxt = done_r ? ST_TERM : ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_BCAST:  if (i_r >= n) state_nxt = ST_IDLE;
      ST_SCAN:   if (i_r >= n) state_nxt = ST_MREAD;
      ST_MREAD:  state_nxt = ST_MCHECK;
      ST_MCHECK: state_nxt = found_r ? ST_SEND : ST_TERM;
      ST_TERM:   if (out_fire) state_nxt = wb_r ? ST_WRS : ST_IDLE;
      ST_SEND:   if (out_fire) state_nxt = ST_RECV;
      ST_RECV:   if (out_fire) state_nxt = fin_r ? ST_FIN : ST_WRT;
      ST_FIN:    if (out_fire) state_nxt = ST_WRT;
      ST_WRT:    state_nxt = ST_WRS;
      ST_WRS:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of each state: result item, table read address, table write
  always_comb begin
    emit_en = 1'b0;
    e_dest  = '0;
    e_cmd   = CMD_TERM;
    e_arg_a = ARG_NONE;
    e_arg_b = ARG_NONE;
    e_last  = 1'b0;
    rd_addr = i_r[IDX_W-1:0];
    wr      = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_chan.op == OP_STAT && {1'b0, in_chan.source} < n) begin
          wr.cnt_we = 1'b1;
          wr.addr   = in_chan.source;
          wr.cnt    = '{q: in_chan.value_a, s: in_chan.value_b};
        end
      end
      ST_BCAST: begin
        emit_en = (i_r < n) && !bc_excl;
        e_dest  = i_r[IDX_W-1:0];
        e_cmd   = CMD_TERM;
        e_arg_a = ARG_W'(src_r);
        e_last  = bc_last;
      end
      ST_MREAD: rd_addr = sm_r;
      ST_TERM: begin
        emit_en = 1'b1;
        e_dest  = src_r;
        e_cmd   = CMD_TERM;
        e_arg_a = ARG_W'(manager_id_r);
        e_last  = 1'b1;
      end
      ST_SEND: begin
        emit_en = 1'b1;
        e_dest  = tgt_r;
        e_cmd   = CMD_SEND;
        e_arg_a = ARG_W'(src_r);
        e_arg_b = ARG_W'(minq_r);
      end
      ST_RECV: begin
        emit_en = 1'b1;
        e_dest  = src_r;
        e_cmd   = CMD_RECV;
        e_arg_a = ARG_W'(tgt_r);
        e_last  = !fin_r;
      end
      ST_FIN: begin
        emit_en = 1'b1;
        e_dest  = sm_r;
        e_cmd   = CMD_FIN;
        e_arg_a = ARG_W'(src_r);
        e_last  = 1'b1;
      end
      ST_WRT: begin
        // Target: take a share of a single item, else give one away
        wr.cnt_we = 1'b1;
        wr.addr   = tgt_r;
        if (minq_r == COUNT_WIDTH'(1)) begin
          wr.cnt.q = minq_r;
          wr.cnt.s = (mins_r == COUNT_MAX) ? mins_r : mins_r + COUNT_WIDTH'(1);
        end else begin
          wr.cnt.q = minq_r - COUNT_WIDTH'(1);
          wr.cnt.s = mins_r;
        end
      end
      ST_WRS: begin
        // Asker: cleared when nothing found, else joined to or detached from target
        wr.cnt_we = 1'b1;
        wr.addr   = src_r;
        if (found_r) begin
          wr.mst_we = 1'b1;
          if (minq_r == COUNT_WIDTH'(1)) begin
            wr.cnt = '{q: n_plus1, s: n_plus1};
            wr.mst = '{vld: 1'b1, id: tgt_r};
          end else begin
            wr.cnt = '{q: COUNT_WIDTH'(1), s: COUNT_WIDTH'(1)};
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && in_chan.op == OP_TERM) begin
        done_r <= 1'b1;
      end
      if (out_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      pv_r <= (state_r == ST_SCAN) && (i_r < n);
    end
  end

  // Scan compare on the entry read in the previous cycle
  logic skip_e;
  assign skip_e = (pidx_r == src_r) || (rd_mst.vld && rd_mst.id == pidx_r);

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      src_r   <= in_chan.source;
      va_r    <= in_chan.value_a;
      i_r     <= '0;
      minq_r  <= n_plus1;
      mins_r  <= n_plus1;
      found_r <= 1'b0;
      tgt_r   <= '0;
      wb_r    <= !done_r;
      smv_r   <= 1'b0;
      sm_r    <= '0;
    end
    if (state_r == ST_SCAN && i_r < n) begin
      i_r <= i_r + NW_W'(1);
    end
    if (state_r == ST_BCAST && i_r < n && (bc_excl || slot_free)) begin
      i_r <= i_r + NW_W'(1);
    end
    pidx_r <= i_r[IDX_W-1:0];
    if (pv_r) begin
      if (pidx_r == src_r) begin
        smv_r <= rd_mst.vld;
        sm_r  <= rd_mst.id;
      end
      if (!skip_e) begin
        if (rd_cnt.q < minq_r && rd_cnt.q != '0) begin
          minq_r  <= rd_cnt.q;
          mins_r  <= rd_cnt.s;
          tgt_r   <= pidx_r;
          found_r <= 1'b1;
        end else if (rd_cnt.q == minq_r && rd_cnt.s < mins_r) begin
          mins_r  <= rd_cnt.s;
          tgt_r   <= pidx_r;
          found_r <= 1'b1;
        end
      end
    end
    // Old master gets a finished notice only if it has no master itself
    if (state_r == ST_MCHECK) begin
      fin_r <= smv_r && !rd_mst.vld;
    end
    if (out_fire) begin
      out_dest_r  <= e_dest;
      out_cmd_r   <= e_cmd;
      out_arg_a_r <= e_arg_a;
      out_arg_b_r <= e_arg_b;
      out_last_r  <= e_last;
    end
  end

endmodule

FILE: sv/wsd_table.sv
`timescale 1ns / 1ps

module wsd_table import wsd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_addr,
  output cnt_t             rd_cnt,
  output mst_t             rd_mst,
  input  tbl_wr_t          wr
);

  cnt_t cnt_mem [NUM_WORKERS];
  mst_t mst_mem [NUM_WORKERS];

  logic [NUM_WORKERS-1:0] cnt_vld_r;
  logic [NUM_WORKERS-1:0] mst_vld_r;
  cnt_t                   cnt_rd_r;
  mst_t                   mst_rd_r;
  logic                   cnt_rv_r;
  logic                   mst_rv_r;

  always_ff @(posedge clk) begin
    if (wr.cnt_we) begin
      cnt_mem[wr.addr] <= wr.cnt;
    end
    if (wr.mst_we) begin
      mst_mem[wr.addr] <= wr.mst;
    end
    cnt_rd_r <= cnt_mem[rd_addr];
    mst_rd_r <= mst_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
      mst_vld_r <= '0;
      cnt_rv_r  <= 1'b0;
      mst_rv_r  <= 1'b0;
    end else begin
      if (wr.cnt_we) begin
        cnt_vld_r[wr.addr] <= 1'b1;
      end
      if (wr.mst_we) begin
        mst_vld_r[wr.addr] <= 1'b1;
      end
      cnt_rv_r <= cnt_vld_r[rd_addr];
      mst_rv_r <= mst_vld_r[rd_addr];
    end
  end

  // An entry never written reads as cleared
  assign rd_cnt = cnt_rv_r ? cnt_rd_r : '0;
  assign rd_mst = mst_rv_r ? mst_rd_r : '0;

endmodule
